>>> rtl/record_header_and_content_checker_macros.svh
// Assertion helpers for the record checker.
// Both forms sample on clk and stay quiet while rst_n is low.
`ifndef RECORD_HEADER_AND_CONTENT_CHECKER_MACROS_SVH
`define RECORD_HEADER_AND_CONTENT_CHECKER_MACROS_SVH

`ifndef NO_ASSERTIONS
// Check that cons holds in the same cycle as ante.
`define RHCC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rhcc assertion failed");
// Check that cons holds in the cycle after ante.
`define RHCC_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rhcc assertion failed");
`else
`define RHCC_ASSERT_IMP(lbl, ante, cons)
`define RHCC_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

>>> rtl/rhcc_pkg.sv
package rhcc_pkg;

  // Record header layout
  localparam int HEADER_BYTES = 20;
  localparam int HDR_CNT_W    = $clog2(HEADER_BYTES + 1);

  // CRC-16, poly 0x1021, init 0, MSB first, final xor 0xFFFF
  localparam logic [15:0] CRC_POLY   = 16'h1021;
  localparam logic [15:0] CRC_INIT   = 16'h0000;
  localparam logic [15:0] CRC_XOROUT = 16'hFFFF;
  localparam logic [7:0]  ERASED_BYTE = 8'hFF;

  // Result status codes
  localparam logic [2:0] ST_OK          = 3'd0;
  localparam logic [2:0] ST_EMPTY       = 3'd1;
  localparam logic [2:0] ST_HDR_CRC_BAD = 3'd2;
  localparam logic [2:0] ST_LEN_OVER    = 3'd3;
  localparam logic [2:0] ST_CONTENT_BAD = 3'd4;

  localparam int IN_TDATA_W  = 8;
  localparam int IN_TUSER_W  = 2;
  localparam int RESULT_W    = 3 + 4 * 32 + 16;
  localparam int OUT_TDATA_W = ((RESULT_W + 7) / 8) * 8;

  // One input request
  typedef struct packed {
    logic [7:0] data_byte;
    logic       record_start;
    logic       with_content;
  } item_t;

  // Input register contents handed to the checker core
  typedef struct packed {
    logic  valid;
    item_t item;
  } stage_t;

  // One result; status sits in the low bits once packed
  typedef struct packed {
    logic [15:0] content_crc;
    logic [31:0] next_offset;
    logic [31:0] content_length;
    logic [31:0] slot_size;
    logic [31:0] record_id;
    logic [2:0]  status;
  } result_t;

  // Core to result register
  typedef struct packed {
    logic    emit;
    result_t res;
  } emit_t;

  // Advance the CRC by one byte, bit by bit
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

>>> rtl/record_header_and_content_checker.sv
// Channel | Dir | Width          | Contents
// in_     | in  | tdata 8, tuser 2 | one record byte, start and content flags
// out_    | out | tdata 152      | status and decoded header fields
//
// One byte is taken per cycle; throughput is one request per clock while
// the result register has room. The last byte of a record passes the
// input register, then the single-pass header/CRC logic into the result
// register, from which the result is offered on out_.
// Reset (synchronous, rst_n low) returns the record state to idle.
// A waiting result stalls only the input register; a new byte is still
// taken while that register is empty.
`include "record_header_and_content_checker_macros.svh"

module record_header_and_content_checker (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [rhcc_pkg::IN_TDATA_W-1:0]  in_tdata,   // [7:0] data_byte
  input  logic [rhcc_pkg::IN_TUSER_W-1:0]  in_tuser,   // [0] record_start, [1] with_content
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // [2:0] status, [34:3] record_id, [66:35] slot_size, [98:67] content_length,
  // [130:99] next_offset, [146:131] content_crc, rest zero
  output logic [rhcc_pkg::OUT_TDATA_W-1:0] out_tdata
);
  import rhcc_pkg::*;

  stage_t s1;
  emit_t  em;
  logic   take;
  logic   out_free;

  rhcc_in_stage u_in (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .take      (take),
    .s1        (s1)
  );

  rhcc_core u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .s1       (s1),
    .out_free (out_free),
    .take     (take),
    .em       (em)
  );

  rhcc_out_stage u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .em         (em),
    .out_free   (out_free),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // A result is produced only when the result register has room
  `RHCC_ASSERT_IMP(a_emit_has_room, em.emit, out_free && take)
  // A produced result is offered on the next cycle
  `RHCC_ASSERT_NXT(a_emit_shows, em.emit, out_tvalid)
  // An empty record reports the erased header fields
  `RHCC_ASSERT_IMP(a_empty_erased, out_tvalid && (out_tdata[2:0] == ST_EMPTY),
                   (out_tdata[34:3] == 32'hFFFF_FFFF) && (out_tdata[146:131] == 16'hFFFF))

endmodule

>>> rtl/rhcc_in_stage.sv
module rhcc_in_stage (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [rhcc_pkg::IN_TDATA_W-1:0] in_tdata,  // [7:0] data_byte
  input  logic [rhcc_pkg::IN_TUSER_W-1:0] in_tuser,  // [0] record_start, [1] with_content
  input  logic                            take,
  output rhcc_pkg::stage_t                s1
);
  import rhcc_pkg::*;

  logic  valid_r, valid_nxt;
  item_t item_r;
  logic  accept;

  // Take a request when empty or when the core drains the held one
  assign in_tready = !valid_r || take;
  assign accept    = in_tvalid && in_tready;

  always_comb begin
    valid_nxt = valid_r;
    if (accept) begin
      valid_nxt = 1'b1;
    end else if (take) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Hold the payload of the accepted request
  always_ff @(posedge clk) begin
    if (accept) begin
      item_r.data_byte    <= in_tdata[7:0];
      item_r.record_start <= in_tuser[0];
      item_r.with_content <= in_tuser[1];
    end
  end

  assign s1.valid = valid_r;
  assign s1.item  = item_r;

endmodule

>>> rtl/rhcc_core.sv
module rhcc_core (
  input  logic             clk,
  input  logic             rst_n,
  input  rhcc_pkg::stage_t s1,
  input  logic             out_free,
  output logic             take,
  output rhcc_pkg::emit_t  em
);
  import rhcc_pkg::*;

  localparam logic [1:0] PH_IDLE    = 2'd0;
  localparam logic [1:0] PH_HEADER  = 2'd1;
  localparam logic [1:0] PH_CONTENT = 2'd2;

  localparam logic [HDR_CNT_W-1:0] HDR_LAST = HDR_CNT_W'(HEADER_BYTES - 1);
  localparam logic [HDR_CNT_W-1:0] CRC_SPAN = HDR_CNT_W'(HEADER_BYTES - 2);

  logic [1:0]           phase_r, phase_nxt;
  logic [HDR_CNT_W-1:0] count_r, count_nxt;
  logic                 erased_r, erased_nxt;
  logic [15:0]          crc_r, crc_nxt;
  logic [31:0]          remain_r, remain_nxt;
  logic                 wanted_r, wanted_nxt;
  logic [7:0]           hdr_r [HEADER_BYTES];

  logic [1:0]           ph;
  logic [HDR_CNT_W-1:0] cnt;
  logic                 ers;
  logic [15:0]          crc;
  logic                 want;
  logic [7:0]           b;
  logic                 hdr_wr;
  logic [15:0]          crc_step;
  logic [15:0]          hdr_crc;
  result_t              fields;

  assign take = s1.valid && out_free;
  assign b    = s1.item.data_byte;

  // Decode header fields from the store, little endian
  assign fields.record_id      = {hdr_r[3],  hdr_r[2],  hdr_r[1],  hdr_r[0]};
  assign fields.slot_size      = {hdr_r[7],  hdr_r[6],  hdr_r[5],  hdr_r[4]};
  assign fields.content_length = {hdr_r[11], hdr_r[10], hdr_r[9],  hdr_r[8]};
  assign fields.next_offset    = {hdr_r[15], hdr_r[14], hdr_r[13], hdr_r[12]};
  assign fields.content_crc    = {hdr_r[17], hdr_r[16]};
  assign fields.status         = ST_OK;

  // Header CRC: low byte already stored, high byte is the current one
  assign hdr_crc = {b, hdr_r[HEADER_BYTES-2]};

  // A record start restarts the context before the byte is used
  always_comb begin
    ph   = s1.item.record_start ? PH_HEADER : phase_r;
    cnt  = s1.item.record_start ? '0 : count_r;
    ers  = s1.item.record_start ? 1'b1 : erased_r;
    crc  = s1.item.record_start ? CRC_INIT : crc_r;
    want = s1.item.record_start ? s1.item.with_content : wanted_r;
  end

  assign crc_step = crc_byte(crc, b);

  // Advance the record state and decide on a result
  always_comb begin
    phase_nxt  = phase_r;
    count_nxt  = count_r;
    erased_nxt = erased_r;
    crc_nxt    = crc_r;
    remain_nxt = remain_r;
    wanted_nxt = wanted_r;
    hdr_wr     = 1'b0;
    em.emit    = 1'b0;
    em.res     = fields;
    if (take) begin
      count_nxt  = cnt;
      erased_nxt = ers;
      crc_nxt    = crc;
      wanted_nxt = want;
      if (s1.item.record_start) begin
        remain_nxt = '0;
      end
      case (ph)
        PH_HEADER: begin
          hdr_wr     = 1'b1;
          phase_nxt  = PH_HEADER;
          erased_nxt = ers && (b == ERASED_BYTE);
          if (cnt < CRC_SPAN) begin
            crc_nxt = crc_step;
          end
          count_nxt = cnt + 1'b1;
          if (cnt == HDR_LAST) begin
            if (erased_nxt) begin
              em.res.status = ST_EMPTY;
            end else if ((crc ^ CRC_XOROUT) != hdr_crc) begin
              em.res.status = ST_HDR_CRC_BAD;
            end else if (fields.content_length > fields.slot_size) begin
              em.res.status = ST_LEN_OVER;
            end
            if (em.res.status != ST_OK || !want) begin
              phase_nxt = PH_IDLE;
              em.emit   = 1'b1;
            end else begin
              remain_nxt = fields.content_length;
              crc_nxt    = CRC_INIT;
              if (fields.content_length == '0) begin
                phase_nxt     = PH_IDLE;
                em.emit       = 1'b1;
                em.res.status = (fields.content_crc == (CRC_INIT ^ CRC_XOROUT)) ?
                                ST_OK : ST_CONTENT_BAD;
              end else begin
                phase_nxt = PH_CONTENT;
              end
            end
          end
        end
        PH_CONTENT: begin
          crc_nxt    = crc_step;
          remain_nxt = remain_r - 32'd1;
          if (remain_r == 32'd1) begin
            phase_nxt     = PH_IDLE;
            em.emit       = 1'b1;
            em.res.status = ((crc_step ^ CRC_XOROUT) == fields.content_crc) ?
                            ST_OK : ST_CONTENT_BAD;
          end
        end
        default: begin
          phase_nxt = PH_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_IDLE;
      count_r  <= '0;
      erased_r <= 1'b1;
      crc_r    <= CRC_INIT;
      remain_r <= '0;
      wanted_r <= 1'b0;
    end else begin
      phase_r  <= phase_nxt;
      count_r  <= count_nxt;
      erased_r <= erased_nxt;
      crc_r    <= crc_nxt;
      remain_r <= remain_nxt;
      wanted_r <= wanted_nxt;
    end
  end

  // Capture header bytes in arrival order
  always_ff @(posedge clk) begin
    if (hdr_wr) begin
      hdr_r[cnt] <= b;
    end
  end

endmodule

>>> rtl/rhcc_out_stage.sv
module rhcc_out_stage (
  input  logic                             clk,
  input  logic                             rst_n,
  input  rhcc_pkg::emit_t                  em,
  output logic                             out_free,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [rhcc_pkg::OUT_TDATA_W-1:0] out_tdata
);
  import rhcc_pkg::*;

  logic    valid_r, valid_nxt;
  result_t res_r;

  // Free when empty or when the waiting request leaves this cycle
  assign out_free = !valid_r || out_tready;

  always_comb begin
    valid_nxt = valid_r;
    if (em.emit) begin
      valid_nxt = 1'b1;
    end else if (out_tready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Load a new result
  always_ff @(posedge clk) begin
    if (em.emit) begin
      res_r <= em.res;
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = {{(OUT_TDATA_W - RESULT_W){1'b0}}, res_r};

endmodule

>>> tb/record_header_and_content_checker_tb.sv
`timescale 1ns / 100ps

module record_header_and_content_checker_tb;
  import rhcc_pkg::*;

  // Shapes of generated records
  typedef enum int {
    RK_GOOD,
    RK_BAD_CONTENT,
    RK_LEN_OVER,
    RK_BAD_HDR_CRC,
    RK_ERASED,
    RK_NEAR_ERASED,
    RK_CUT_SHORT
  } rec_kind_t;

  // Predicts the header/content verdicts and checks results in order
  class record_scoreboard;
    typedef enum logic [1:0] {REC_IDLE, REC_HEADER, REC_CONTENT} rec_stage_t;

    rec_stage_t  stage;
    int unsigned hdr_fill;
    bit [7:0]    hdr_bytes[HEADER_BYTES];
    bit          still_erased;
    bit [15:0]   crc_acc;
    bit [31:0]   bytes_left;
    bit          check_content;
    result_t     awaited[$];
    int          errors;

    function new();
      stage            = REC_IDLE;
      hdr_fill         = 0;
      still_erased     = 1'b1;
      crc_acc          = CRC_INIT;
      bytes_left       = '0;
      check_content    = 1'b0;
      errors           = 0;
    endfunction

    // CRC-16/0x1021, MSB first, one byte
    static function bit [15:0] crc16_step(bit [15:0] c, bit [7:0] b);
      bit fb;
      for (int i = 7; i >= 0; i--) begin
        fb = c[15] ^ b[i];
        c  = {c[14:0], 1'b0};
        if (fb) begin
          c = c ^ CRC_POLY;
        end
      end
      return c;
    endfunction

    function bit [31:0] le32(int at);
      return {hdr_bytes[at + 3], hdr_bytes[at + 2], hdr_bytes[at + 1], hdr_bytes[at]};
    endfunction

    function bit [15:0] le16(int at);
      return {hdr_bytes[at + 1], hdr_bytes[at]};
    endfunction

    // Queue the decoded header with a verdict
    function void push_header_result(logic [2:0] verdict);
      result_t r;
      r.status         = verdict;
      r.record_id      = le32(0);
      r.slot_size      = le32(4);
      r.content_length = le32(8);
      r.next_offset    = le32(12);
      r.content_crc    = le16(16);
      awaited.push_back(r);
    endfunction

    // Advance the record state by one accepted request
    function void take_byte(bit [7:0] b, bit first, bit with_body);
      logic [2:0] verdict;
      if (first) begin
        stage         = REC_HEADER;
        hdr_fill      = 0;
        still_erased  = 1'b1;
        crc_acc       = CRC_INIT;
        bytes_left    = '0;
        check_content = with_body;
      end
      case (stage)
        REC_HEADER: begin
          if (hdr_fill < HEADER_BYTES) begin
            hdr_bytes[hdr_fill] = b;
            if (b != ERASED_BYTE) begin
              still_erased = 1'b0;
            end
            if (hdr_fill < HEADER_BYTES - 2) begin
              crc_acc = crc16_step(crc_acc, b);
            end
            hdr_fill++;
          end
          if (hdr_fill >= HEADER_BYTES) begin
            if (still_erased) begin
              verdict = ST_EMPTY;
            end else if ((crc_acc ^ CRC_XOROUT) != le16(18)) begin
              verdict = ST_HDR_CRC_BAD;
            end else if (le32(8) > le32(4)) begin
              verdict = ST_LEN_OVER;
            end else begin
              verdict = ST_OK;
            end
            if (verdict != ST_OK || !check_content) begin
              stage = REC_IDLE;
              push_header_result(verdict);
            end else begin
              bytes_left = le32(8);
              crc_acc    = CRC_INIT;
              if (bytes_left == 0) begin
                // empty content: CRC of nothing is the xor-out value
                stage = REC_IDLE;
                push_header_result((CRC_XOROUT == le16(16)) ? ST_OK : ST_CONTENT_BAD);
              end else begin
                stage = REC_CONTENT;
              end
            end
          end
        end
        REC_CONTENT: begin
          crc_acc    = crc16_step(crc_acc, b);
          bytes_left = bytes_left - 1;
          if (bytes_left == 0) begin
            stage = REC_IDLE;
            push_header_result(((crc_acc ^ CRC_XOROUT) == le16(16)) ? ST_OK : ST_CONTENT_BAD);
          end
        end
        default: begin
          // bytes outside a record are dropped
          stage = REC_IDLE;
        end
      endcase
    endfunction

    function int outstanding();
      return awaited.size();
    endfunction

    task report(string msg);
      $display("%0t MISMATCH %s", $time, msg);
      errors++;
    endtask

    task compare_field(string name, logic [31:0] got, logic [31:0] want);
      if (got !== want) begin
        report($sformatf("%s got %h want %h", name, got, want));
      end
    endtask

    // Compare one accepted result with the oldest expectation
    task check_result(logic [OUT_TDATA_W-1:0] word);
      result_t got;
      result_t want;
      got = result_t'(word[RESULT_W-1:0]);
      if (word[OUT_TDATA_W-1:RESULT_W] !== '0) begin
        report("out_tdata pad bits not zero");
      end
      if (awaited.size() == 0) begin
        report($sformatf("result with none pending, status %0d", got.status));
        return;
      end
      want = awaited.pop_front();
      compare_field("status", 32'(got.status), 32'(want.status));
      compare_field("record_id", got.record_id, want.record_id);
      compare_field("slot_size", got.slot_size, want.slot_size);
      compare_field("content_length", got.content_length, want.content_length);
      compare_field("next_offset", got.next_offset, want.next_offset);
      compare_field("content_crc", 32'(got.content_crc), 32'(want.content_crc));
    endtask
  endclass

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic [IN_TUSER_W-1:0]  in_tuser = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;

  record_scoreboard sb = new();
  int  calm_in = 0;
  int  calm_out = 0;
  int  record_bytes = 0;
  bit  hold_off_req = 1'b0;
  bit  hold_off_done = 1'b0;

  record_header_and_content_checker i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Mostly short gaps, a few long ones, and calm stretches with none
  function automatic int pick_gap(inout int calm);
    int r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 5) begin
      calm = $urandom_range(20, 80);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic bit [31:0] pick_word();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 32'h0000_0000;
    if (r == 1) return 32'hFFFF_FFFF;
    return $urandom();
  endfunction

  function automatic rec_kind_t pick_kind();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return RK_GOOD;
    if (r < 60) return RK_BAD_CONTENT;
    if (r < 70) return RK_LEN_OVER;
    if (r < 80) return RK_BAD_HDR_CRC;
    if (r < 86) return RK_ERASED;
    if (r < 91) return RK_NEAR_ERASED;
    return RK_CUT_SHORT;
  endfunction

  // Offer one request and hold it until accepted
  task automatic send_request(bit [7:0] d, bit first, bit with_body);
    int gap;
    gap = pick_gap(calm_in);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= d;
    in_tuser  <= {with_body, first};
    do @(posedge clk); while (!in_tready);
    sb.take_byte(d, first, with_body);
  endtask

  // Build one record of a random shape and stream it
  task automatic play_record();
    rec_kind_t kind;
    bit [31:0] words[4];
    bit [31:0] slot;
    bit [31:0] len;
    bit [15:0] ccrc;
    bit [15:0] hcrc;
    bit        wc;
    bit [7:0]  body[$];
    bit [7:0]  rec[$];
    int        cut;
    kind = pick_kind();
    wc   = ($urandom_range(0, 3) != 0);
    if (wc) begin
      len  = ($urandom_range(0, 4) == 0) ? 32'd0 : 32'($urandom_range(1, 12));
      slot = ($urandom_range(0, 5) == 0) ? 32'hFFFF_FFFF :
             len + (($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5000));
      repeat (len) body.push_back(8'($urandom_range(0, 255)));
    end else begin
      slot = pick_word();
      len  = ($urandom_range(0, 3) == 0) ? slot : (slot & $urandom());
    end
    ccrc = CRC_INIT;
    foreach (body[i]) ccrc = record_scoreboard::crc16_step(ccrc, body[i]);
    ccrc = ccrc ^ CRC_XOROUT;

    // corrupt according to the chosen shape
    case (kind)
      RK_BAD_CONTENT: ccrc = ccrc ^ (16'h1 << $urandom_range(0, 15));
      RK_LEN_OVER: begin
        if (slot == 32'hFFFF_FFFF) slot = slot - 1;
        len = slot + 1 + ($urandom() % (32'hFFFF_FFFF - slot));
        body.delete();
      end
      default: ;
    endcase

    words = '{pick_word(), slot, len, pick_word()};
    foreach (words[w]) begin
      for (int i = 0; i < 4; i++) rec.push_back(words[w][8*i +: 8]);
    end
    rec.push_back(ccrc[7:0]);
    rec.push_back(ccrc[15:8]);
    hcrc = CRC_INIT;
    foreach (rec[i]) hcrc = record_scoreboard::crc16_step(hcrc, rec[i]);
    hcrc = hcrc ^ CRC_XOROUT;
    if (kind == RK_BAD_HDR_CRC) begin
      hcrc = hcrc ^ (16'h1 << $urandom_range(0, 15));
      body.delete();
    end
    rec.push_back(hcrc[7:0]);
    rec.push_back(hcrc[15:8]);

    if (kind == RK_ERASED || kind == RK_NEAR_ERASED) begin
      rec.delete();
      body.delete();
      repeat (HEADER_BYTES) rec.push_back(ERASED_BYTE);
      if (kind == RK_NEAR_ERASED) begin
        rec[$urandom_range(0, HEADER_BYTES - 1)] = 8'($urandom_range(0, 255));
      end
    end
    rec = {rec, body};

    // abandon partway; the next start takes over
    if (kind == RK_CUT_SHORT) begin
      cut = $urandom_range(1, rec.size() - 1);
      rec = rec[0:cut-1];
    end

    foreach (rec[i]) begin
      send_request(rec[i], i == 0, (i == 0) ? wc : 1'($urandom_range(0, 1)));
    end
    record_bytes += rec.size();

    // stray bytes between records
    if ($urandom_range(0, 4) == 0) begin
      repeat ($urandom_range(1, 3)) begin
        send_request(8'($urandom_range(0, 255)), 1'b0, 1'($urandom_range(0, 1)));
      end
    end
  endtask

  // Result side ready: random gaps plus one long hold-off
  initial begin
    int gap;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_off_req && !hold_off_done) begin
        out_tready <= 1'b0;
        repeat (400) @(posedge clk);
        hold_off_done = 1'b1;
      end
      gap = pick_gap(calm_out);
      if (gap > 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
    end
  end

  // Check every accepted result
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      sb.check_result(out_tdata);
    end
  end

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: stray bytes at the extremes, an abandoned start, an erased header
    send_request(8'h00, 1'b0, 1'b1);
    send_request(8'hFF, 1'b0, 1'b0);
    send_request(8'h00, 1'b1, 1'b0);
    for (int i = 0; i < HEADER_BYTES; i++) begin
      send_request(ERASED_BYTE, i == 0, 1'b1);
    end

    // Random records; the long hold-off starts here
    hold_off_req = 1'b1;
    while (record_bytes < 800) begin
      play_record();
    end
    in_tvalid <= 1'b0;

    // Drain, then allow the pipeline latency to pass
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #1000000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

>>> filelist.f
+incdir+rtl
rtl/rhcc_pkg.sv
rtl/rhcc_in_stage.sv
rtl/rhcc_core.sv
rtl/rhcc_out_stage.sv
rtl/record_header_and_content_checker.sv
tb/record_header_and_content_checker_tb.sv
